// ----- hw/rtl/drc_pkg.sv -----
// Shared types and constants for the dirty rectangle coalescer.
// Used by the channel interfaces and by the top level; depends on nothing.
package drc_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned BorderW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CoordW-1:0]  EmptyEdge        = 16'hffff;
  localparam logic [CoordW-1:0]  ModeWidthReset   = 16'd1024;
  localparam logic [CoordW-1:0]  ModeHeightReset  = 16'd768;
  localparam logic [BorderW-1:0] BorderReset      = 8'd50;

  typedef enum logic [1:0] {
    OP_UPDATE     = 2'd0,
    OP_TICK       = 2'd1,
    OP_DRAW_BEGIN = 2'd2,
    OP_PEER_ACK   = 2'd3
  } drc_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE_WIDTH  = 2'd0,
    REG_MODE_HEIGHT = 2'd1,
    REG_BORDER      = 2'd2,
    REG_UNUSED      = 2'd3
  } drc_reg_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CoordW-1:0] rect_left;
    logic [CoordW-1:0] rect_top;
    logic [CoordW-1:0] rect_right;
    logic [CoordW-1:0] rect_bottom;
  } drc_in_t;

  typedef struct packed {
    logic              report_valid;
    logic [CoordW-1:0] out_left;
    logic [CoordW-1:0] out_top;
    logic [CoordW-1:0] out_right;
    logic [CoordW-1:0] out_bottom;
    logic              draw_permitted;
  } drc_out_t;

endpackage

// ----- hw/rtl/drc_in_if.sv -----
// Input channel of the dirty rectangle coalescer: valid, ready and one item.
// Depends on drc_pkg for the payload type.
interface drc_in_if;
  logic             valid;
  logic             ready;
  drc_pkg::drc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/drc_out_if.sv -----
// Result channel of the dirty rectangle coalescer: valid, ready and one item.
// Depends on drc_pkg for the payload type.
interface drc_out_if;
  logic              valid;
  logic              ready;
  drc_pkg::drc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dirty_rect_coalescer.sv -----
// Dirty rectangle coalescer: merges damage rectangles into a bounding box
// and reports the grown, clipped box on armed ticks.
// Depends on drc_pkg, drc_in_if and drc_out_if.
//
//   channel   direction  payload                                   items
//   in_i      sink       opcode, rect_left/top/right/bottom        one command
//   out_o     source     report_valid, out_*, draw_permitted       one result
//   cfg_*     write      mode_width, mode_height, border           -
//
// Each item is held in the input register and then passes through the
// min/max, grow and clip logic into the result register. One item per
// cycle is sustained unless the result stalls. The box state updates as
// the item leaves the input register. A stalled result holds both
// registers; rst_ni clears them and loads the box and config reset values.
module dirty_rect_coalescer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  drc_in_if.sink                        in_i,
  drc_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [drc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [drc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import drc_pkg::*;

  logic [CoordW-1:0]  mode_width_q, mode_height_q;
  logic [BorderW-1:0] border_q;

  logic    in_valid_q;
  drc_in_t in_q;
  logic    out_valid_q;
  drc_out_t out_q, out_d;

  logic [CoordW-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
  logic [CoordW-1:0] box_left_d, box_top_d, box_right_d, box_bottom_d;
  logic force_q, force_d, send_ready_q, send_ready_d;
  logic draw_ok_q, draw_ok_d, armed_q, armed_d;

  logic advance, report;
  logic [CoordW-1:0] grown_left, grown_top, grown_right, grown_bottom;
  logic [CoordW:0]   sum_right, sum_bottom;
  drc_op_e op;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign op          = drc_op_e'(in_q.opcode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_width_q  <= ModeWidthReset;
      mode_height_q <= ModeHeightReset;
      border_q      <= BorderReset;
    end else if (cfg_we_i) begin
      case (drc_reg_e'(cfg_idx_i))
        REG_MODE_WIDTH:  mode_width_q  <= cfg_data_i;
        REG_MODE_HEIGHT: mode_height_q <= cfg_data_i;
        REG_BORDER:      border_q      <= cfg_data_i[BorderW-1:0];
        default: ;
      endcase
    end
  end

  // Grow the current box by the border; left and top only shrink when they
  // exceed it, right and bottom saturate at the largest coordinate.
  always_comb begin
    grown_left  = (box_left_q > {8'd0, border_q}) ? box_left_q - {8'd0, border_q} : box_left_q;
    grown_top   = (box_top_q > {8'd0, border_q}) ? box_top_q - {8'd0, border_q} : box_top_q;
    sum_right   = {1'b0, box_right_q} + {9'd0, border_q};
    sum_bottom  = {1'b0, box_bottom_q} + {9'd0, border_q};
    grown_right  = sum_right[CoordW] ? EmptyEdge : sum_right[CoordW-1:0];
    grown_bottom = sum_bottom[CoordW] ? EmptyEdge : sum_bottom[CoordW-1:0];
  end

  always_comb begin
    box_left_d   = box_left_q;
    box_top_d    = box_top_q;
    box_right_d  = box_right_q;
    box_bottom_d = box_bottom_q;
    force_d      = force_q;
    send_ready_d = send_ready_q;
    draw_ok_d    = draw_ok_q;
    armed_d      = armed_q;
    report       = 1'b0;
    out_d        = '0;
    case (op)
      OP_UPDATE: begin
        if (in_q.rect_left < box_left_q)     box_left_d   = in_q.rect_left;
        if (in_q.rect_top < box_top_q)       box_top_d    = in_q.rect_top;
        if (in_q.rect_right > box_right_q)   box_right_d  = in_q.rect_right;
        if (in_q.rect_bottom > box_bottom_q) box_bottom_d = in_q.rect_bottom;
        send_ready_d = 1'b1;
      end
      OP_TICK: begin
        if (armed_q) begin
          report = (box_right_q != '0) && (box_bottom_q != '0) && (send_ready_q || force_q);
          if (report) begin
            draw_ok_d         = 1'b0;
            force_d           = 1'b0;
            out_d.report_valid = 1'b1;
            out_d.out_left   = (grown_left > mode_width_q) ? '0 : grown_left;
            out_d.out_top    = (grown_top > mode_height_q) ? '0 : grown_top;
            out_d.out_right  = (grown_right > mode_width_q) ? mode_width_q : grown_right;
            out_d.out_bottom = (grown_bottom > mode_height_q) ? mode_height_q : grown_bottom;
            box_left_d   = EmptyEdge;
            box_top_d    = EmptyEdge;
            box_right_d  = '0;
            box_bottom_d = '0;
          end
          if (!send_ready_q) force_d = 1'b1;
        end
      end
      OP_DRAW_BEGIN: send_ready_d = 1'b0;
      OP_PEER_ACK: begin
        armed_d   = 1'b1;
        draw_ok_d = 1'b1;
      end
      default: ;
    endcase
    out_d.draw_permitted = draw_ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      box_left_q   <= '0;
      box_top_q    <= '0;
      box_right_q  <= '0;
      box_bottom_q <= '0;
      force_q      <= 1'b0;
      send_ready_q <= 1'b1;
      draw_ok_q    <= 1'b1;
      armed_q      <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q  <= 1'b1;
        box_left_q   <= box_left_d;
        box_top_q    <= box_top_d;
        box_right_q  <= box_right_d;
        box_bottom_q <= box_bottom_d;
        force_q      <= force_d;
        send_ready_q <= send_ready_d;
        draw_ok_q    <= draw_ok_d;
        armed_q      <= armed_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
    if (advance) out_q <= out_d;
  end

`ifndef SYNTH
  a_report_revokes_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.report_valid |-> !out_q.draw_permitted)
    else $error("report delivered with draw permission still set");

  a_report_empties_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && report |=> box_right_q == '0 && box_bottom_q == '0 && !draw_ok_q)
    else $error("box not emptied after a report");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked result");
`endif

endmodule
